// ----- hdl/dcc_pkg.sv -----
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants of the DCC packet bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

  localparam int PCNT_W    = 6;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;

  localparam logic [PCNT_W-1:0] PCNT_RST   = PCNT_W'(14);
  localparam logic [LEN_W-1:0]  LEN_RST    = LEN_W'(1);
  localparam logic [CNT_W-1:0]  BYTE_TOP   = CNT_W'(7);

  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CUTOUT_ENABLE  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BIT_ZERO         = 2'd0,
    BIT_ONE          = 2'd1,
    BIT_CUTOUT_START = 2'd2,
    BIT_CUTOUT       = 2'd3
  } bit_kind_t;

  typedef enum logic [1:0] {
    PH_CUTOUT   = 2'd0,
    PH_PREAMBLE = 2'd1,
    PH_DATA     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] bit_kind;
    logic       packet_latched;
    logic       cutout_ended;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] wr_val;
    logic [LEN_W-1:0]  wr_len;
    logic              take;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/dcc_ifs.sv -----
// ----------------------------------------------------------------------------
// dcc_ifs
// Valid/ready channels of the sequencer: items in, bits out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcc_in_if import dcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] byte_value;
  logic [LEN_W-1:0]  packet_length;

  modport source (output valid, cmd, byte_index, byte_value, packet_length, input ready);
  modport sink   (input valid, cmd, byte_index, byte_value, packet_length, output ready);
endinterface

interface dcc_out_if import dcc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] bit_kind;
  logic       packet_latched;
  logic       cutout_ended;

  modport source (output valid, bit_kind, packet_latched, cutout_ended, input ready);
  modport sink   (input valid, bit_kind, packet_latched, cutout_ended, output ready);
endinterface

interface dcc_cfg_if import dcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/dcc_pkt_store.sv -----
// ----------------------------------------------------------------------------
// dcc_pkt_store
// Pending packet written by the host and current packet being sent.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_pkt_store import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire store_ctl_t                          ctl,
  input  wire logic [$clog2(MAX_PACKET_BYTES)-1:0] rd_pos,
  output      logic [BYTE_W-1:0]                   cur_byte,
  output      logic [LEN_W-1:0]                    cur_len
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES);
  localparam int WI_W  = (POS_W > IDX_W) ? POS_W : IDX_W;

  logic [BYTE_W-1:0] pend_r [MAX_PACKET_BYTES];
  logic [BYTE_W-1:0] cur_r  [MAX_PACKET_BYTES];
  logic [LEN_W-1:0]  pend_len_r, pend_len_nxt;
  logic [LEN_W-1:0]  cur_len_r;

  always_comb begin
    pend_len_nxt = ctl.wr_len;
    if (ctl.wr_len == '0) begin
      pend_len_nxt = LEN_W'(1);
    end else if (int'(ctl.wr_len) > MAX_PACKET_BYTES) begin
      pend_len_nxt = LEN_W'(MAX_PACKET_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
      if (ctl.wr_en && (WI_W'(ctl.wr_idx) == WI_W'(i))) begin
        pend_r[i] <= ctl.wr_val;
      end
      if (ctl.take) begin
        cur_r[i] <= pend_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_len_r <= LEN_RST;
      cur_len_r  <= LEN_RST;
    end else begin
      if (ctl.wr_en) begin
        pend_len_r <= pend_len_nxt;
      end
      if (ctl.take) begin
        cur_len_r <= pend_len_r;
      end
    end
  end

  assign cur_byte = cur_r[rd_pos];
  assign cur_len  = cur_len_r;

endmodule

`default_nettype wire

// ----- hdl/dcc_seq_core.sv -----
// ----------------------------------------------------------------------------
// dcc_seq_core
// Frame sequencer: phase, bit counter and byte position, one step per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_seq_core import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 8,
  parameter int CUTOUT_BITS      = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                tick,
  input  wire logic                                restart,
  input  wire logic [PCNT_W-1:0]                   pcnt,
  input  wire logic                                cut_en,
  input  wire logic [BYTE_W-1:0]                   cur_byte,
  input  wire logic [LEN_W-1:0]                    cur_len,
  output      logic [$clog2(MAX_PACKET_BYTES)-1:0] rd_pos,
  output      logic                                take,
  output      res_t                                res
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES);
  localparam int CMP_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
  localparam logic signed [CNT_W-1:0] CUT_TOP = CNT_W'(CUTOUT_BITS);

  phase_t                   phase_r, phase_nxt;
  logic signed [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [CNT_W-1:0]  pc_full, pc_less;
  logic                     last_byte;

  assign pc_full   = CNT_W'(pcnt);
  assign pc_less   = pc_full - CNT_W'(1);
  assign last_byte = (CMP_W'(pos_r) + CMP_W'(1)) >= CMP_W'(cur_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREAMBLE;
      cnt_r   <= CNT_W'(PCNT_RST);
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    take      = 1'b0;
    res       = '{bit_kind: BIT_ONE, packet_latched: 1'b0, cutout_ended: 1'b0};
    if (restart) begin
      phase_nxt = PH_PREAMBLE;
      cnt_nxt   = pc_full;
    end else if (tick) begin
      unique case (phase_r)
        PH_CUTOUT: begin
          if (cnt_r == CUT_TOP) begin
            res.bit_kind = BIT_CUTOUT_START;
            cnt_nxt      = cnt_r - CNT_W'(1);
          end else if (cnt_r > 0) begin
            res.bit_kind = BIT_CUTOUT;
            cnt_nxt      = cnt_r - CNT_W'(1);
          end else begin
            phase_nxt = PH_PREAMBLE;
            cnt_nxt   = pc_less;
          end
        end
        PH_PREAMBLE: begin
          if (cnt_r > 0) begin
            res.cutout_ended = (cnt_r == pc_less) && cut_en;
            cnt_nxt          = cnt_r - CNT_W'(1);
          end else begin
            res.bit_kind       = BIT_ZERO;
            res.packet_latched = 1'b1;
            take               = 1'b1;
            phase_nxt          = PH_DATA;
            pos_nxt            = '0;
            cnt_nxt            = BYTE_TOP;
          end
        end
        default: begin
          if (cnt_r < 0) begin
            if (last_byte) begin
              phase_nxt = cut_en ? PH_CUTOUT : PH_PREAMBLE;
              cnt_nxt   = cut_en ? CUT_TOP : pc_less;
            end else begin
              res.bit_kind = BIT_ZERO;
              pos_nxt      = pos_r + POS_W'(1);
              cnt_nxt      = BYTE_TOP;
            end
          end else begin
            res.bit_kind = cur_byte[cnt_r[2:0]] ? BIT_ONE : BIT_ZERO;
            cnt_nxt      = cnt_r - CNT_W'(1);
          end
        end
      endcase
    end
  end

  assign rd_pos = pos_r;

endmodule

`default_nettype wire

// ----- hdl/dcc_packet_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// dcc_packet_bit_sequencer
// DCC track bit serializer with optional cutout, top level.
// ----------------------------------------------------------------------------
// Each accepted item is one command: a bit tick returns the kind of the next
// track bit (preamble ones, start zero, data MSB first with zero separators,
// stop one, then an optional cutout), a byte write loads the pending packet,
// and a restart returns to a full preamble; writes and restarts return
// nothing. One item is accepted per clock unless the input is held; each item
// goes into the input register, and a tick's result is written into the result
// register. The result register and the input register decouple the two
// sides, so a stalled output only holds the input once both are full.
// Register writes are taken at any time and should be made while idle.
`default_nettype none

module dcc_packet_bit_sequencer import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 8,
  parameter int CUTOUT_BITS      = 4
) (
  input wire logic clk,
  input wire logic rst_n,
  dcc_in_if.sink   in_ch,
  dcc_out_if.source out_ch,
  dcc_cfg_if.sink  cfg_ch
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES);

  logic              q_valid_r;
  cmd_t              q_cmd_r;
  logic [IDX_W-1:0]  q_idx_r;
  logic [BYTE_W-1:0] q_val_r;
  logic [LEN_W-1:0]  q_len_r;
  logic              proc;
  logic              out_free;

  logic              out_valid_r;
  res_t              out_res_r;

  logic [PCNT_W-1:0] pcnt_r;
  logic              cut_en_r;

  store_ctl_t        ctl;
  res_t              res;
  logic              take;
  logic [POS_W-1:0]  rd_pos;
  logic [BYTE_W-1:0] cur_byte;
  logic [LEN_W-1:0]  cur_len;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign proc        = q_valid_r && (out_free || (q_cmd_r != CMD_TICK));
  assign in_ch.ready = !q_valid_r || proc;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      q_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      q_cmd_r <= cmd_t'(in_ch.cmd);
      q_idx_r <= in_ch.byte_index;
      q_val_r <= in_ch.byte_value;
      q_len_r <= in_ch.packet_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r   <= PCNT_RST;
      cut_en_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_PREAMBLE_COUNT: pcnt_r   <= cfg_ch.wr_data[PCNT_W-1:0];
        REG_CUTOUT_ENABLE:  cut_en_r <= cfg_ch.wr_data[0];
        default: ;
      endcase
    end
  end

  assign ctl = '{
    wr_en:  proc && (q_cmd_r == CMD_WRITE),
    wr_idx: q_idx_r,
    wr_val: q_val_r,
    wr_len: q_len_r,
    take:   take
  };

  dcc_seq_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .CUTOUT_BITS      (CUTOUT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (proc && (q_cmd_r == CMD_TICK)),
    .restart  (proc && (q_cmd_r == CMD_RESTART)),
    .pcnt     (pcnt_r),
    .cut_en   (cut_en_r),
    .cur_byte (cur_byte),
    .cur_len  (cur_len),
    .rd_pos   (rd_pos),
    .take     (take),
    .res      (res)
  );

  dcc_pkt_store #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_pos   (rd_pos),
    .cur_byte (cur_byte),
    .cur_len  (cur_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && (q_cmd_r == CMD_TICK)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (q_cmd_r == CMD_TICK)) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bit_kind       = out_res_r.bit_kind;
  assign out_ch.packet_latched = out_res_r.packet_latched;
  assign out_ch.cutout_ended   = out_res_r.cutout_ended;

`ifndef SYNTH
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (q_cmd_r == CMD_TICK)) |=> out_valid_r)
    else $error("bit tick did not load the result register");

  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid_r && !proc) |-> (out_valid_r && !out_ch.ready))
    else $error("input stage held without a stalled result");

  a_latch_on_start_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && take) |=> (out_res_r.bit_kind == BIT_ZERO && out_res_r.packet_latched))
    else $error("packet taken without a start bit");

  a_ended_on_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.cutout_ended) |-> (out_res_r.bit_kind == BIT_ONE && cut_en_r))
    else $error("cutout end flagged off a preamble one");
`endif

endmodule

`default_nettype wire

// ----- test/tb_dcc_packet_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_dcc_packet_bit_sequencer
// Self-checking bench for the DCC packet bit sequencer.
// ----------------------------------------------------------------------------
// Commands go in over the input channel with random gaps. A bit-level model
// of the frame sequencer (preamble, start bit, data bytes with separators,
// stop bit, optional cutout) predicts the track bit of every tick. The output
// side stalls at random. Each bit is checked field by field in order.
// Register writes are made only while idle, across several preamble lengths
// and both cutout modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dcc_packet_bit_sequencer import dcc_pkg::*; ;

  localparam int MAX_PACKET_BYTES = 8;
  localparam int CUTOUT_BITS      = 4;
  localparam int SETTLE_CYCLES    = 8;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dcc_in_if  cmd_if ();
  dcc_out_if bit_if ();
  dcc_cfg_if reg_if ();

  dcc_packet_bit_sequencer #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .CUTOUT_BITS(CUTOUT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(cmd_if),
    .out_ch(bit_if),
    .cfg_ch(reg_if)
  );

  // frame model state
  int          preamble_ones;
  bit          cutout_on;
  phase_t      seq_phase;
  int          bit_count;
  int          byte_pos;
  logic [7:0]  cur_bytes  [MAX_PACKET_BYTES];
  logic [7:0]  pend_bytes [MAX_PACKET_BYTES];
  int          cur_len;
  int          pend_len;

  res_t        expected_bits [$];
  res_t        want_bit;
  int          err_count;
  int          bits_checked;

  bit          in_gaps_on;
  bit          out_stalls_on;
  int          out_hold;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: bit %0d: %s", $realtime, bits_checked, msg);
    err_count++;
  endtask

  function automatic res_t next_track_bit();
    res_t r;
    r.bit_kind       = BIT_ONE;
    r.packet_latched = 1'b0;
    r.cutout_ended   = 1'b0;
    case (seq_phase)
      PH_CUTOUT: begin
        if (bit_count == CUTOUT_BITS) begin
          r.bit_kind = BIT_CUTOUT_START;
          bit_count--;
        end else if (bit_count > 0) begin
          r.bit_kind = BIT_CUTOUT;
          bit_count--;
        end else begin
          seq_phase = PH_PREAMBLE;
          bit_count = preamble_ones - 1;
        end
      end
      PH_PREAMBLE: begin
        if (bit_count > 0) begin
          if (bit_count == preamble_ones - 1 && cutout_on)
            r.cutout_ended = 1'b1;
          bit_count--;
        end else begin
          r.bit_kind       = BIT_ZERO;
          r.packet_latched = 1'b1;
          seq_phase        = PH_DATA;
          byte_pos         = 0;
          bit_count        = BYTE_TOP;
          cur_bytes        = pend_bytes;
          cur_len          = pend_len;
        end
      end
      default: begin
        if (bit_count < 0) begin
          if (byte_pos + 1 >= cur_len) begin
            if (cutout_on) begin
              seq_phase = PH_CUTOUT;
              bit_count = CUTOUT_BITS;
            end else begin
              seq_phase = PH_PREAMBLE;
              bit_count = preamble_ones - 1;
            end
          end else begin
            r.bit_kind = BIT_ZERO;
            byte_pos++;
            bit_count = BYTE_TOP;
          end
        end else begin
          r.bit_kind = cur_bytes[byte_pos][bit_count] ? BIT_ONE : BIT_ZERO;
          bit_count--;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void apply_command(input cmd_t cmd, input logic [2:0] idx,
                                        input logic [7:0] val, input logic [3:0] len);
    case (cmd)
      CMD_TICK: expected_bits.push_back(next_track_bit());
      CMD_WRITE: begin
        pend_bytes[idx] = val;
        if (len < 1)
          pend_len = 1;
        else if (len > MAX_PACKET_BYTES)
          pend_len = MAX_PACKET_BYTES;
        else
          pend_len = len;
      end
      CMD_RESTART: begin
        seq_phase = PH_PREAMBLE;
        bit_count = preamble_ones;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int unsigned roll;
    if (!in_gaps_on)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65)
      return 0;
    if (roll < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_command(input cmd_t cmd, input logic [2:0] idx,
                              input logic [7:0] val, input logic [3:0] len);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.cmd           <= cmd;
    cmd_if.byte_index    <= idx;
    cmd_if.byte_value    <= val;
    cmd_if.packet_length <= len;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    apply_command(cmd, idx, val, len);
  endtask

  task automatic send_tick();
    send_command(CMD_TICK, 3'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    reg_if.valid     <= 1'b1;
    reg_if.reg_index <= idx;
    reg_if.wr_data   <= data;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
    if (idx == REG_PREAMBLE_COUNT)
      preamble_ones = data[PCNT_W-1:0];
    else if (idx == REG_CUTOUT_ENABLE)
      cutout_on = data[0];
    @(negedge clk);
    reg_if.valid <= 1'b0;
  endtask

  task automatic run_random_items(input int n_items);
    int unsigned roll;
    logic [3:0]  len;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        in_gaps_on    = $urandom_range(0, 2) != 0;
        out_stalls_on = $urandom_range(0, 2) != 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 84) begin
        send_tick();
      end else if (roll < 94) begin
        roll = $urandom_range(0, 9);
        if (roll < 8)
          len = 4'($urandom_range(1, 4));
        else if (roll < 9)
          len = 4'($urandom_range(5, 8));
        else
          len = 4'($urandom);
        send_command(CMD_WRITE, 3'($urandom), 8'($urandom), len);
      end else if (roll < 97) begin
        send_command(CMD_NONE, 3'($urandom), 8'($urandom), 4'($urandom));
      end else begin
        send_command(CMD_RESTART, 3'($urandom), 8'($urandom), 4'($urandom));
      end
    end
  endtask

  // all pending entries get written before the first start bit
  task automatic test_pending_writes();
    logic [7:0] vals [8] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'h7E, 8'hC3};
    logic [3:0] lens [8] = '{4'd15, 4'd9, 4'd8, 4'd4, 4'd2, 4'd3, 4'd1, 4'd0};
    for (int i = 0; i < 8; i++)
      send_command(CMD_WRITE, 3'(i), vals[i], lens[i]);
    send_command(CMD_NONE, 3'd7, 8'hFF, 4'hF);
  endtask

  task automatic test_reset_defaults();
    run_random_items(60);
  endtask

  task automatic test_short_preamble_cutout();
    wait_idle();
    write_reg(REG_PREAMBLE_COUNT, 8'hC0);
    write_reg(REG_CUTOUT_ENABLE, 8'h01);
    send_command(CMD_WRITE, 3'd0, 8'hA5, 4'd0);
    send_command(CMD_RESTART, 3'd5, 8'h3C, 4'd6);
    repeat (16) send_tick();
  endtask

  task automatic test_settings_sweep();
    int pc_set [7]    = '{3, 40, 1, 63, 0, 7, 14};
    bit ce_set [7]    = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    int items_set [7] = '{60, 100, 50, 100, 40, 50, 40};
    int pc;
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      if (p < 7) begin
        pc = pc_set[p];
        write_reg(REG_PREAMBLE_COUNT, {2'($urandom), 6'(pc)});
        write_reg(REG_CUTOUT_ENABLE, {7'($urandom), ce_set[p]});
        run_random_items(items_set[p]);
      end else begin
        pc = $urandom_range(2, 12);
        write_reg(REG_CUTOUT_ENABLE, {7'($urandom), 1'($urandom)});
        write_reg(REG_PREAMBLE_COUNT, {2'($urandom), 6'(pc)});
        run_random_items(40);
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n || !out_stalls_on) begin
      bit_if.ready <= 1'b1;
    end else if (out_hold > 0) begin
      bit_if.ready <= 1'b0;
      out_hold--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3:  begin
          bit_if.ready <= 1'b0;
          out_hold = $urandom_range(0, 2);
        end
        4: begin
          bit_if.ready <= 1'b0;
          out_hold = $urandom_range(10, 40);
        end
        default: bit_if.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && bit_if.valid && bit_if.ready) begin
      if (expected_bits.size() == 0) begin
        report_mismatch("track bit with nothing expected");
      end else begin
        want_bit = expected_bits.pop_front();
        if (bit_if.bit_kind !== want_bit.bit_kind)
          report_mismatch($sformatf("bit_kind got %0d want %0d",
                                    bit_if.bit_kind, want_bit.bit_kind));
        if (bit_if.packet_latched !== want_bit.packet_latched)
          report_mismatch($sformatf("packet_latched got %0b want %0b",
                                    bit_if.packet_latched, want_bit.packet_latched));
        if (bit_if.cutout_ended !== want_bit.cutout_ended)
          report_mismatch($sformatf("cutout_ended got %0b want %0b",
                                    bit_if.cutout_ended, want_bit.cutout_ended));
      end
      bits_checked++;
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.cmd           = CMD_TICK;
    cmd_if.byte_index    = '0;
    cmd_if.byte_value    = '0;
    cmd_if.packet_length = '0;
    reg_if.valid         = 1'b0;
    reg_if.reg_index     = REG_PREAMBLE_COUNT;
    reg_if.wr_data       = '0;
    bit_if.ready         = 1'b0;
    err_count            = 0;
    bits_checked         = 0;
    out_hold             = 0;
    in_gaps_on           = 1'b1;
    out_stalls_on        = 1'b1;
    preamble_ones        = PCNT_RST;
    cutout_on            = 1'b0;
    seq_phase            = PH_PREAMBLE;
    bit_count            = PCNT_RST;
    byte_pos             = 0;
    cur_len              = LEN_RST;
    pend_len             = LEN_RST;
    for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
      cur_bytes[i]  = '0;
      pend_bytes[i] = '0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pending_writes();
    test_reset_defaults();
    test_short_preamble_cutout();
    test_settings_sweep();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
